/* src/kgbr_pkg.sv */
// shared constants and types for the k-group block reverser
`default_nettype none
package kgbr_pkg;
    localparam int MAX_GROUP = 16;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 5;
    localparam int IDX_W     = $clog2(MAX_GROUP);
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);
    localparam int KW        = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } cell_ctrl_t;
endpackage
`default_nettype wire

/* src/kgbr_cell.sv */
// one storage cell of the group chain
`default_nettype none
module kgbr_cell (
    input  wire                                     aclk,
    input  wire kgbr_pkg::cell_ctrl_t               ctrl,
    input  wire logic signed [kgbr_pkg::DATA_W-1:0] from_below,
    input  wire logic signed [kgbr_pkg::DATA_W-1:0] from_above,
    output logic signed [kgbr_pkg::DATA_W-1:0]      q
);
    logic signed [kgbr_pkg::DATA_W-1:0] data_reg;
    logic signed [kgbr_pkg::DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.shift_up) begin
            data_next = from_below;
        end else if (ctrl.shift_down) begin
            data_next = from_above;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q = data_reg;
endmodule
`default_nettype wire

/* src/kgbr_cell_row.sv */
// row of cells: newest item enters cell 0, older items move up
`default_nettype none
module kgbr_cell_row (
    input  wire                                     aclk,
    input  wire kgbr_pkg::cell_ctrl_t               ctrl,
    input  wire logic signed [kgbr_pkg::DATA_W-1:0] in_value,
    input  wire logic [kgbr_pkg::IDX_W-1:0]         rd_idx,
    output logic signed [kgbr_pkg::DATA_W-1:0]      head_value,
    output logic signed [kgbr_pkg::DATA_W-1:0]      sel_value
);
    logic signed [kgbr_pkg::DATA_W-1:0] q [kgbr_pkg::MAX_GROUP];

    for (genvar i = 0; i < kgbr_pkg::MAX_GROUP; i++) begin : g_cell
        logic signed [kgbr_pkg::DATA_W-1:0] below;
        logic signed [kgbr_pkg::DATA_W-1:0] above;
        if (i == 0) begin : g_first
            assign below = in_value;
        end else begin : g_inner_b
            assign below = q[i-1];
        end
        if (i == kgbr_pkg::MAX_GROUP - 1) begin : g_last
            assign above = q[i];
        end else begin : g_inner_a
            assign above = q[i+1];
        end
        kgbr_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .from_below (below),
            .from_above (above),
            .q          (q[i])
        );
    end

    assign head_value = q[0];
    assign sel_value  = q[rd_idx];
endmodule
`default_nettype wire

/* src/k_group_block_reverser_top.sv */
// top level: group collection, drain sequencing and output register
// Items enter a chain of cells one per cycle while a group is collected. When an item
// completes a group of group_size (clamped to 16), ends the list, or arrives with
// group_size 0 or 1, input stalls while the held items drain, one result per cycle
// into the output register unless m_ready stalls it; the next item is accepted only
// after the last result of the drain has been loaded into the output register.
// A full group drains reversed by shifting the chain toward cell 0; a closing partial
// group drains in arrival order through a read select across the row.
`default_nettype none
module k_group_block_reverser_top (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire                                     cfg_we,
    input  wire logic [kgbr_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire                                     s_valid,
    output logic                                    s_ready,
    input  wire logic signed [kgbr_pkg::DATA_W-1:0] s_value,
    input  wire                                     s_end_of_list,
    output logic                                    m_valid,
    input  wire                                     m_ready,
    output logic signed [kgbr_pkg::DATA_W-1:0]      m_out_value,
    output logic                                    m_end_of_run,
    output logic                                    m_out_end_of_list
);
    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_DRAIN   = 1'b1;

    logic                           state_reg, state_next;
    logic [kgbr_pkg::CFG_W-1:0]     group_size_reg, group_size_next;
    logic [kgbr_pkg::CNT_W-1:0]     fill_reg, fill_next;
    logic [kgbr_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic                           rev_reg, rev_next;
    logic                           eol_reg, eol_next;
    logic                           m_valid_reg, m_valid_next;
    logic signed [kgbr_pkg::DATA_W-1:0] m_value_reg, m_value_next;
    logic                           m_eor_reg, m_eor_next;
    logic                           m_eol_reg, m_eol_next;

    kgbr_pkg::cell_ctrl_t           ctrl;
    logic signed [kgbr_pkg::DATA_W-1:0] head_value, sel_value;
    logic [kgbr_pkg::IDX_W-1:0]     rd_idx;
    logic [kgbr_pkg::KW-1:0]        k_raw, k_eff, n_w;
    logic [kgbr_pkg::CNT_W-1:0]     n_cnt;
    logic                           accept, slot_free, emit_step, last_step;
    logic                           full_group, go_drain;

    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign emit_step = (state_reg == ST_DRAIN) && slot_free;
    assign last_step = (rem_reg == kgbr_pkg::CNT_W'(1));
    assign rd_idx    = kgbr_pkg::IDX_W'(rem_reg - kgbr_pkg::CNT_W'(1));

    assign k_raw = kgbr_pkg::KW'(group_size_reg);
    assign k_eff = (k_raw > kgbr_pkg::KW'(kgbr_pkg::MAX_GROUP))
                 ? kgbr_pkg::KW'(kgbr_pkg::MAX_GROUP) : k_raw;
    assign n_cnt = fill_reg + kgbr_pkg::CNT_W'(1);
    assign n_w   = kgbr_pkg::KW'(n_cnt);
    assign full_group = (k_eff >= kgbr_pkg::KW'(2)) && (n_w >= k_eff);
    assign go_drain   = full_group || (k_eff <= kgbr_pkg::KW'(1)) || s_end_of_list;

    assign ctrl.shift_up   = accept;
    assign ctrl.shift_down = emit_step && rev_reg;

    kgbr_cell_row u_row (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .in_value   (s_value),
        .rd_idx     (rd_idx),
        .head_value (head_value),
        .sel_value  (sel_value)
    );

    always_comb begin
        state_next      = state_reg;
        group_size_next = cfg_we ? cfg_wdata : group_size_reg;
        fill_next       = fill_reg;
        rem_next        = rem_reg;
        rev_next        = rev_reg;
        eol_next        = eol_reg;
        m_valid_next    = m_valid_reg;
        m_value_next    = m_value_reg;
        m_eor_next      = m_eor_reg;
        m_eol_next      = m_eol_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_COLLECT: begin
                if (accept) begin
                    if (go_drain) begin
                        fill_next  = '0;
                        rem_next   = n_cnt;
                        rev_next   = full_group;
                        eol_next   = s_end_of_list;
                        state_next = ST_DRAIN;
                    end else begin
                        fill_next = n_cnt;
                    end
                end
            end
            ST_DRAIN: begin
                if (emit_step) begin
                    m_valid_next = 1'b1;
                    m_value_next = rev_reg ? head_value : sel_value;
                    m_eor_next   = last_step;
                    m_eol_next   = last_step && eol_reg;
                    rem_next     = rem_reg - kgbr_pkg::CNT_W'(1);
                    if (last_step) begin
                        state_next = ST_COLLECT;
                    end
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_COLLECT;
            group_size_reg <= kgbr_pkg::CFG_W'(1);
            fill_reg       <= '0;
            rem_reg        <= '0;
            rev_reg        <= 1'b0;
            eol_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            group_size_reg <= group_size_next;
            fill_reg       <= fill_next;
            rem_reg        <= rem_next;
            rev_reg        <= rev_next;
            eol_reg        <= eol_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg <= m_value_next;
        m_eor_reg   <= m_eor_next;
        m_eol_reg   <= m_eol_next;
    end

    assign s_ready           = (state_reg == ST_COLLECT);
    assign m_valid           = m_valid_reg;
    assign m_out_value       = m_value_reg;
    assign m_end_of_run      = m_eor_reg;
    assign m_out_end_of_list = m_eol_reg;

    a_eol_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_end_of_list |-> m_end_of_run)
        else $error("end of list without end of run");

    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DRAIN |-> rem_reg != '0)
        else $error("drain with no items left");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < kgbr_pkg::CNT_W'(kgbr_pkg::MAX_GROUP))
        else $error("group fill overflow");

    a_pass_single: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && fill_reg == '0 && k_eff <= kgbr_pkg::KW'(1)
        |=> state_reg == ST_DRAIN && rem_reg == kgbr_pkg::CNT_W'(1))
        else $error("pass-through item not drained alone");
endmodule
`default_nettype wire
